// File: design/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg
// shared types and codes for the pollard rho factor finder
// ----------------------------------------------------------------------------
package prf_pkg;

    localparam logic [1:0] OUTCOME_FOUND  = 2'd0;
    localparam logic [1:0] OUTCOME_FAILED = 2'd1;
    localparam logic [1:0] OUTCOME_LIMIT  = 2'd2;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_INC   = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    // operations of the shared unit
    typedef enum logic [1:0] {
        OP_MOD,
        OP_MULMOD,
        OP_DIV
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_C,
        S_RED_X,
        S_STEP_X,
        S_STEP_Y1,
        S_STEP_Y2,
        S_GCD,
        S_COF,
        S_DONE
    } t_state;

endpackage

// File: design/prf_alu.sv
// ----------------------------------------------------------------------------
// prf_alu
// multi-cycle shared unit: a mod m, a*a+c mod m, a / m, one bit per cycle
// ----------------------------------------------------------------------------
module prf_alu #(
    parameter int W = 63
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  prf_pkg::t_op    i_op,
    input  logic [W-1:0]    i_a,
    input  logic [W-1:0]    i_c,
    input  logic [W-1:0]    i_m,
    output logic            o_done,
    output logic [W-1:0]    o_res
);
    import prf_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    t_op           r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_acc, n_acc;   // remainder or product accumulator
    logic [W-1:0]  r_a, n_a;       // multiplicand doubling / dividend bits
    logic [W-1:0]  r_b, n_b;       // multiplier bits / quotient
    logic [W-1:0]  r_c, n_c;
    logic [W-1:0]  r_m, n_m;
    logic          r_done, n_done;

    // modular add of two values below m
    function automatic logic [W-1:0] add_mod(
        input logic [W-1:0] a, input logic [W-1:0] b, input logic [W-1:0] m);
        logic [W-1:0] room;
        room = m - b;
        return (a >= room) ? (a - room) : (a + b);
    endfunction

    always_comb begin
        logic [W:0] rem2;
        n_busy = r_busy;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_c    = r_c;
        n_m    = r_m;
        n_done = 1'b0;
        rem2   = {r_acc, r_a[W-1]};
        if (!r_busy) begin
            if (i_go) begin
                n_busy = 1'b1;
                n_op   = i_op;
                n_cnt  = CW'(W);
                n_acc  = '0;
                n_a    = i_a;
                n_b    = (i_op == OP_MULMOD) ? i_a : '0;
                n_c    = i_c;
                n_m    = i_m;
            end
        end else if (r_cnt == '0) begin
            n_busy = 1'b0;
            n_done = 1'b1;
            if (r_op == OP_MULMOD)
                n_acc = add_mod(r_acc, r_c, r_m);
        end else begin
            n_cnt = r_cnt - 1'b1;
            unique case (r_op)
                OP_MULMOD: begin
                    if (r_b[0])
                        n_acc = add_mod(r_acc, r_a, r_m);
                    n_a = add_mod(r_a, r_a, r_m);
                    n_b = r_b >> 1;
                end
                default: begin
                    // restoring division, msb first
                    n_a = r_a << 1;
                    if (rem2 >= {1'b0, r_m}) begin
                        n_acc = W'(rem2 - {1'b0, r_m});
                        n_b   = {r_b[W-2:0], 1'b1};
                    end else begin
                        n_acc = rem2[W-1:0];
                        n_b   = {r_b[W-2:0], 1'b0};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_m   <= n_m;
    end

    assign o_done = r_done;
    assign o_res  = (r_op == OP_DIV) ? r_b : r_acc;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_no_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != '0 |=> r_busy) else $error("unit quit early");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");
endmodule

// File: design/pollard_rho_factor_finder.sv
// ----------------------------------------------------------------------------
// pollard_rho_factor_finder
// pollard rho factor search with floyd cycle detection
// ----------------------------------------------------------------------------
// one word in, one word out: a start pulse with busy low takes n, and the
// result appears for one cycle with o_valid; the receiver cannot stall it.
// every operation runs on one shared bit-serial unit. an iteration costs
// three mulmod ops plus a euclid gcd of up to ~1.5*NUMBER_WIDTH remainder
// ops; busy stays high throughout. configuration writes are accepted only
// while the block is idle and no start is offered, so an item in flight
// never sees a register change.
module pollard_rho_factor_finder #(
    parameter int NUMBER_WIDTH = 63,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [NUMBER_WIDTH-1:0] i_number_to_factor,
    output logic                    o_valid,
    output logic [NUMBER_WIDTH-1:0] o_found_factor,
    output logic [NUMBER_WIDTH-1:0] o_cofactor,
    output logic [1:0]              o_outcome,
    output logic [COUNT_WIDTH-1:0]  o_iterations_used,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [NUMBER_WIDTH-1:0] i_cfg_data
);
    import prf_pkg::*;

    localparam int W = NUMBER_WIDTH;

    // configuration registers
    logic [W-1:0]           r_start_value;
    logic [W-1:0]           r_inc;
    logic [COUNT_WIDTH-1:0] r_limit;

    // search state
    t_state                 r_state, n_state;
    logic [W-1:0]           r_n, n_n;
    logic [W-1:0]           r_c, n_c;
    logic [W-1:0]           r_x, n_x;
    logic [W-1:0]           r_y, n_y;
    logic [W-1:0]           r_ga, n_ga;     // gcd operands
    logic [W-1:0]           r_gb, n_gb;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   r_wait, n_wait; // unit op in flight
    logic                   r_valid, n_valid;
    logic [W-1:0]           r_fac, n_fac;
    logic [W-1:0]           r_cof, n_cof;
    logic [1:0]             r_out, n_out;

    // shared unit hookup
    logic         u_go, u_done;
    t_op          u_op;
    logic [W-1:0] u_a, u_c, u_m, u_res;

    prf_alu #(.W(W)) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (u_go),
        .i_op   (u_op),
        .i_a    (u_a),
        .i_c    (u_c),
        .i_m    (u_m),
        .o_done (u_done),
        .o_res  (u_res)
    );

    // writes only between items
    assign o_cfg_ready = !busy && !start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_value <= W'(2);
            r_inc         <= W'(1);
            r_limit       <= COUNT_WIDTH'(65536);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_START: r_start_value <= i_cfg_data;
                REG_INC:   r_inc         <= i_cfg_data;
                REG_LIMIT: r_limit       <= i_cfg_data[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_n = r_n; n_c = r_c; n_x = r_x; n_y = r_y;
        n_ga = r_ga; n_gb = r_gb; n_cnt = r_cnt;
        n_wait = r_wait; n_valid = 1'b0;
        n_fac = r_fac; n_cof = r_cof; n_out = r_out;
        u_go = 1'b0; u_op = OP_MOD; u_a = '0; u_c = r_c; u_m = r_n;
        unique case (r_state)
            S_IDLE: begin
                // no new word while the result is still shown
                if (start && !r_valid) begin
                    n_n   = i_number_to_factor;
                    n_cnt = '0;
                    n_cof = '0;
                    n_wait = 1'b0;
                    if (i_number_to_factor < W'(2)) begin
                        n_fac = i_number_to_factor;
                        n_out = OUTCOME_FAILED;
                        n_state = S_DONE;
                    end else begin
                        n_fac = '0;
                        n_out = OUTCOME_LIMIT;
                        n_state = S_RED_C;
                    end
                end
            end
            S_RED_C: begin
                u_op = OP_MOD; u_a = r_inc;
                if (!r_wait) begin
                    u_go = 1'b1; n_wait = 1'b1;
                end else if (u_done) begin
                    n_c = u_res; n_wait = 1'b0; n_state = S_RED_X;
                end
            end
            S_RED_X: begin
                u_op = OP_MOD; u_a = r_start_value;
                if (!r_wait) begin
                    u_go = 1'b1; n_wait = 1'b1;
                end else if (u_done) begin
                    n_x = u_res; n_y = u_res; n_wait = 1'b0;
                    n_state = (r_limit == '0) ? S_DONE : S_STEP_X;
                end
            end
            S_STEP_X: begin
                u_op = OP_MULMOD; u_a = r_x;
                if (!r_wait) begin
                    u_go = 1'b1; n_wait = 1'b1;
                end else if (u_done) begin
                    n_x = u_res; n_wait = 1'b0; n_state = S_STEP_Y1;
                end
            end
            S_STEP_Y1, S_STEP_Y2: begin
                u_op = OP_MULMOD; u_a = r_y;
                if (!r_wait) begin
                    u_go = 1'b1; n_wait = 1'b1;
                end else if (u_done) begin
                    n_y = u_res; n_wait = 1'b0;
                    if (r_state == S_STEP_Y1) begin
                        n_state = S_STEP_Y2;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                        // gcd(n, |x-y|)
                        n_ga = r_n;
                        n_gb = (r_x >= u_res) ? (r_x - u_res) : (u_res - r_x);
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                u_op = OP_MOD; u_a = r_ga; u_m = r_gb;
                if (r_gb == '0) begin
                    n_fac = r_ga;
                    if (r_ga == W'(1)) begin
                        n_state = (r_cnt == r_limit) ? S_DONE : S_STEP_X;
                    end else if (r_ga == r_n) begin
                        n_out = OUTCOME_FAILED; n_state = S_DONE;
                    end else begin
                        n_out = OUTCOME_FOUND; n_state = S_COF;
                    end
                end else if (!r_wait) begin
                    u_go = 1'b1; n_wait = 1'b1;
                end else if (u_done) begin
                    n_ga = r_gb; n_gb = u_res; n_wait = 1'b0;
                end
            end
            S_COF: begin
                u_op = OP_DIV; u_a = r_n; u_m = r_fac;
                if (!r_wait) begin
                    u_go = 1'b1; n_wait = 1'b1;
                end else if (u_done) begin
                    n_cof = u_res; n_wait = 1'b0; n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_valid <= n_valid;
        end
        r_n <= n_n; r_c <= n_c; r_x <= n_x; r_y <= n_y;
        r_ga <= n_ga; r_gb <= n_gb; r_cnt <= n_cnt;
        r_fac <= n_fac; r_cof <= n_cof; r_out <= n_out;
    end

    // busy also covers the cycle the result is shown
    assign busy              = (r_state != S_IDLE) || r_valid;
    assign o_valid           = r_valid;
    assign o_found_factor    = r_fac;
    assign o_cofactor        = r_cof;
    assign o_outcome         = r_out;
    assign o_iterations_used = r_cnt;

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid) else $error("result held");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_cnt <= r_limit) else $error("limit overrun");
    a_found_cof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out != OUTCOME_FOUND |-> r_cof == '0) else $error("bad cofactor");
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == S_DONE) else $error("stray result");
endmodule

// File: verif/pollard_rho_factor_finder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pollard_rho_factor_finder_tb
// self-checking bench for the pollard rho factor finder
// ----------------------------------------------------------------------------
// words go in through the start/busy handshake, register writes through the
// cfg channel. a local rho search predicts each result word when n is taken,
// and every o_valid word is compared field by field against the oldest
// prediction. iteration limits stay small in most tests so the bit-serial
// unit keeps the run short; only a few items use full-width n.
module pollard_rho_factor_finder_tb;
    import prf_pkg::*;

    localparam int NW = 63;
    localparam int CW = 32;
    localparam int STALL_LIMIT = 8000000;
    localparam logic [NW-1:0] NMAX = {NW{1'b1}};
    // index with no register behind it
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct {
        logic [NW-1:0] factor;
        logic [NW-1:0] cofactor;
        logic [1:0]    outcome;
        logic [CW-1:0] iterations;
    } t_factorization;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [NW-1:0] i_number_to_factor;
    logic          o_valid;
    logic [NW-1:0] o_found_factor;
    logic [NW-1:0] o_cofactor;
    logic [1:0]    o_outcome;
    logic [CW-1:0] o_iterations_used;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index;
    logic [NW-1:0] i_cfg_data;

    // mirror of the block's registers
    logic [NW-1:0] seed_mirror;
    logic [NW-1:0] inc_mirror;
    logic [CW-1:0] limit_mirror;

    t_factorization pending_factorizations[$];
    int  mismatch_count;
    int  stall_cycles;

    pollard_rho_factor_finder #(.NUMBER_WIDTH(NW), .COUNT_WIDTH(CW)) dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // one step of the map, v*v + c mod n, product taken at full width
    function automatic logic [NW-1:0] rho_map(logic [NW-1:0] v, logic [NW-1:0] c,
                                              logic [NW-1:0] n);
        logic [127:0] p;
        p = 128'(v) * 128'(v);
        p = p % 128'(n);
        p = (p + 128'(c)) % 128'(n);
        return p[NW-1:0];
    endfunction

    function automatic logic [NW-1:0] euclid_gcd(logic [NW-1:0] a, logic [NW-1:0] b);
        logic [NW-1:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_factorization factorize_n(logic [NW-1:0] n);
        t_factorization r;
        logic [NW-1:0] x, y, c, d, diff;
        r.factor = '0;
        r.cofactor = '0;
        r.outcome = OUTCOME_LIMIT;
        r.iterations = '0;
        if (n < 2) begin
            // nothing to search: n comes back as a failed factor
            r.factor = n;
            r.outcome = OUTCOME_FAILED;
            return r;
        end
        c = inc_mirror % n;
        x = seed_mirror % n;
        y = x;
        while (r.iterations < limit_mirror) begin
            x = rho_map(x, c, n);
            y = rho_map(rho_map(y, c, n), c, n);
            r.iterations++;
            diff = (x >= y) ? x - y : y - x;
            d = euclid_gcd(diff, n);
            r.factor = d;
            if (d != 1) begin
                if (d == n) begin
                    r.outcome = OUTCOME_FAILED;
                end else begin
                    r.outcome = OUTCOME_FOUND;
                    r.cofactor = n / d;
                end
                break;
            end
        end
        return r;
    endfunction

    // predict on each taken word, track register writes, check result words
    always @(posedge i_clk) begin
        t_factorization e;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_START: seed_mirror  <= i_cfg_data;
                    REG_INC:   inc_mirror   <= i_cfg_data;
                    REG_LIMIT: limit_mirror <= i_cfg_data[CW-1:0];
                    default: ;  // unknown index is dropped
                endcase
            end
            if (start && !busy)
                pending_factorizations.push_back(factorize_n(i_number_to_factor));
            if (o_valid) begin
                if (pending_factorizations.size() == 0) begin
                    $error("result word with no prediction waiting");
                    mismatch_count++;
                end else begin
                    e = pending_factorizations.pop_front();
                    if (o_found_factor !== e.factor) begin
                        $error("found_factor expected %0d actual %0d", e.factor,
                               o_found_factor);
                        mismatch_count++;
                    end
                    if (o_cofactor !== e.cofactor) begin
                        $error("cofactor expected %0d actual %0d", e.cofactor, o_cofactor);
                        mismatch_count++;
                    end
                    if (o_outcome !== e.outcome) begin
                        $error("outcome expected %0d actual %0d", e.outcome, o_outcome);
                        mismatch_count++;
                    end
                    if (o_iterations_used !== e.iterations) begin
                        $error("iterations_used expected %0d actual %0d", e.iterations,
                               o_iterations_used);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no word taken, no register write and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    task automatic send_number(logic [NW-1:0] n);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_number_to_factor <= n;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // let the block drain before touching registers
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_factorizations.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [NW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        // small n under reset registers; primes end as failed
        send_number(63'd0);
        send_number(63'd1);
        send_number(63'd2);
        send_number(63'd3);
        send_number(63'd4);
        send_number(63'd15);
        send_number(63'd97);
        send_number(63'd8051);
        send_number(63'd10403);
        drain();
    endtask

    task automatic test_limit_edges();
        write_reg(REG_LIMIT, 63'd0);
        send_number(63'd8051);
        send_number(NMAX);
        drain();
        write_reg(REG_LIMIT, 63'd1);
        send_number(63'd10403);
        send_number(NMAX);
        drain();
        write_reg(REG_LIMIT, {31'd0, 32'hFFFF_FFFF});
        send_number(63'd91);
        send_number(63'd65537);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_LIMIT, 63'd4);
        write_reg(REG_START, 63'd0);
        write_reg(REG_INC, NMAX);
        send_number(63'd221);
        send_number(NMAX);
        drain();
        write_reg(REG_START, NMAX);
        write_reg(REG_INC, 63'd1);
        send_number(63'd1147);
        send_number(63'd2);
        drain();
        write_reg(REG_NONE, NMAX);
        send_number(63'd323);
        drain();
    endtask

    function automatic logic [NW-1:0] pick_number(int big_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < big_pct)
            return NW'({$urandom, $urandom});
        if (r < 75)
            return NW'($urandom_range(2, 511)) * NW'($urandom_range(2, 511));
        return NW'($urandom_range(0, 65535));
    endfunction

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(REG_START, (phase % 2) ? NW'({$urandom, $urandom})
                                             : NW'($urandom_range(0, 9)));
            write_reg(REG_INC, (phase % 3 == 0) ? NW'({$urandom, $urandom})
                                                : NW'($urandom_range(1, 7)));
            write_reg(REG_LIMIT, NW'($urandom_range(1, 3)));
            for (int k = 0; k < 14; k++)
                send_number(pick_number(15));
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_number_to_factor = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_START;
        i_cfg_data = '0;
        seed_mirror = 63'd2;
        inc_mirror = 63'd1;
        limit_mirror = 32'd65536;
        mismatch_count = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_limit_edges();
        test_register_extremes();
        test_random_phases();

        drain();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
